// ===== rtl/core/seu_pkg.sv =====
`default_nettype none
package seu_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_UPPER_U   = 8'h55;

  localparam logic [3:0] DIGITS_X       = 4'd2;
  localparam logic [3:0] DIGITS_LOWER_U = 4'd4;
  localparam logic [3:0] DIGITS_UPPER_U = 4'd8;

  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3 = 8'he0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
  localparam logic [5:0] UTF8_MASK  = 6'h3f;

  localparam logic [31:0] CP_LIMIT1 = 32'h0000_0080;
  localparam logic [31:0] CP_LIMIT2 = 32'h0000_0800;
  localparam logic [31:0] CP_LIMIT3 = 32'h0001_0000;

  // One request from the front part: either one to four data bytes or a
  // single marker result that carries no byte.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            marker;
    logic            err;
    logic            done;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    logic [7:0] b;
    unique case (c)
      8'h61:   b = 8'h07;
      8'h62:   b = 8'h08;
      8'h65:   b = 8'h1b;
      8'h66:   b = 8'h0c;
      8'h6e:   b = 8'h0a;
      8'h72:   b = 8'h0d;
      8'h74:   b = 8'h09;
      default: b = c;
    endcase
    return b;
  endfunction

  function automatic entry_t utf8_encode(input logic [31:0] cp);
    entry_t e;
    e = '0;
    if (cp < CP_LIMIT1) begin
      e.bytes[0] = cp[7:0];
      e.last_idx = 2'd0;
    end else if (cp < CP_LIMIT2) begin
      e.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
      e.bytes[1] = UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK};
      e.last_idx = 2'd1;
    end else if (cp < CP_LIMIT3) begin
      e.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
      e.bytes[1] = UTF8_CONT | {2'd0, cp[11:6]};
      e.bytes[2] = UTF8_CONT | {2'd0, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      // Lead byte keeps only the low eight bits of the shifted code point.
      e.bytes[0] = UTF8_LEAD4 | cp[25:18];
      e.bytes[1] = UTF8_CONT | {2'd0, cp[17:12]};
      e.bytes[2] = UTF8_CONT | {2'd0, cp[11:6]};
      e.bytes[3] = UTF8_CONT | {2'd0, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/seu_front.sv =====
`default_nettype none
module seu_front
  import seu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            push,
  output entry_t          push_entry
);

  mode_t       mode_r, mode_nxt;
  logic [3:0]  digits_r, digits_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        skip_r, skip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      digits_r <= '0;
      accum_r  <= '0;
      skip_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      accum_r  <= accum_nxt;
      skip_r   <= skip_nxt;
    end
  end

  always_comb begin
    logic        accept;
    logic        flag;
    hex_t        hv;
    logic [31:0] acc_new;
    logic [3:0]  dig_new;

    accept     = in_valid && in_ready;
    flag       = 1'b0;
    hv         = hex_value(in_char);
    acc_new    = {accum_r[27:0], hv.val};
    dig_new    = digits_r - 4'd1;
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    accum_nxt  = accum_r;
    skip_nxt   = skip_r;
    push       = 1'b0;
    push_entry = '0;

    if (accept) begin
      if (!skip_r) begin
        unique case (mode_r)
          MODE_ESCAPE: begin
            mode_nxt = MODE_NORMAL;
            if (in_char == CH_LOWER_X || in_char == CH_LOWER_U ||
                in_char == CH_UPPER_U) begin
              mode_nxt   = MODE_HEX;
              digits_nxt = (in_char == CH_LOWER_X) ? DIGITS_X :
                           (in_char == CH_LOWER_U) ? DIGITS_LOWER_U : DIGITS_UPPER_U;
              accum_nxt  = '0;
              flag       = in_last;
            end else begin
              push                = 1'b1;
              push_entry.bytes[0] = escape_byte(in_char);
            end
          end
          MODE_HEX: begin
            if (!hv.ok || digits_r == 4'd0) begin
              flag = 1'b1;
            end else begin
              accum_nxt  = acc_new;
              digits_nxt = dig_new;
              if (dig_new == 4'd0) begin
                mode_nxt   = MODE_NORMAL;
                push       = 1'b1;
                push_entry = utf8_encode(acc_new);
                accum_nxt  = '0;
              end else begin
                flag = in_last;
              end
            end
          end
          default: begin
            mode_nxt = MODE_NORMAL;
            if (in_char == CH_BACKSLASH) begin
              mode_nxt = MODE_ESCAPE;
            end else begin
              push                = 1'b1;
              push_entry.bytes[0] = in_char;
            end
          end
        endcase
      end

      if (flag) begin
        push              = 1'b1;
        push_entry        = '0;
        push_entry.marker = 1'b1;
        push_entry.err    = 1'b1;
        skip_nxt          = 1'b1;
        mode_nxt          = MODE_NORMAL;
        digits_nxt        = '0;
        accum_nxt         = '0;
      end

      if (in_last) begin
        if (!push) begin
          push_entry.marker = 1'b1;
        end
        push            = 1'b1;
        push_entry.done = 1'b1;
        mode_nxt        = MODE_NORMAL;
        digits_nxt      = '0;
        accum_nxt       = '0;
        skip_nxt        = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/seu_queue.sv =====
`default_nettype none
module seu_queue
  import seu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  entry_t    push_entry,
  output logic      full,
  output logic      head_valid,
  output entry_t    head_entry,
  input  wire logic pop
);

  entry_t            slot_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]     count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == (PtrW+1)'(QueueDepth));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (PtrW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/seu_back.sv =====
`default_nettype none
module seu_back
  import seu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  entry_t          head_entry,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic [2:0]      out_tuser
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic [2:0] user_r, user_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    user_r <= user_nxt;
  end

  // The output register reloads whenever it is empty or being drained, so a
  // multi-byte request streams out at one byte per cycle while out_tready is high.
  always_comb begin
    logic load;
    logic at_end;

    load      = !valid_r || out_tready;
    at_end    = (idx_r == head_entry.last_idx);
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    user_nxt  = user_r;
    pop       = 1'b0;

    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        data_nxt = head_entry.marker ? 8'd0 : head_entry.bytes[idx_r];
        last_nxt = at_end;
        user_nxt = {head_entry.done && at_end, head_entry.err, !head_entry.marker};
        if (at_end) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

// ===== rtl/core/string_escape_utf8_decoder_unit.sv =====
`default_nettype none
// Channel   Direction  Ports                       Contents
// in_       slave      tvalid tready tdata tlast   tdata[7:0] body byte, tlast literal end
// out_      master     tvalid tready tdata tlast   tdata[7:0] decoded byte, tlast last of run,
//                      tuser                       tuser[0] byte valid, [1] escape error,
//                                                  [2] literal done
//
// One input byte is taken per cycle while the four-entry queue has room.
// Each byte yields zero to four results; the back end emits one per cycle while
// out_tready is high, so throughput is bounded by the output side at one result
// per cycle. An input byte is written to the queue, and its results leave through the output register.
// Reset is synchronous and active low; it empties the queue and returns the
// decoder to normal mode. Output stalls fill the queue before in_tready drops.
module string_escape_utf8_decoder_unit
  import seu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_char
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,
  output logic [2:0]      out_tuser   // [0] byte_valid, [1] escape_error, [2] literal_done
);

  logic   push, full, head_valid, pop;
  entry_t push_entry, head_entry;

  assign in_tready = !full;

  seu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  seu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  seu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/core/seu_checker.sv =====
`default_nettype none
module seu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [2:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  a_err_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tlast)
    else $error("escape error must be a single marker result");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("literal done on a result that is not last");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0)
    else $error("marker result carries a nonzero byte");

endmodule

bind string_escape_utf8_decoder_unit seu_checker u_seu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== tb/sv/unescape_checker.sv =====
`timescale 1ns / 1ps
module unescape_checker
  import seu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_char
  input  wire logic       in_tlast,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,  // [7:0] out_byte
  input  wire logic       out_tlast,
  input  wire logic [2:0] out_tuser,  // [0] byte_valid, [1] escape_error, [2] literal_done
  output int              mismatches,
  output int              pending,
  output int              checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       esc_err;
    logic       lit_done;
  } decoded_t;

  decoded_t    expected_bytes[$];
  decoded_t    step_results[$];
  mode_t       mode;
  logic [3:0]  digits_left;
  logic [31:0] code_accum;
  logic        skip_rest;

  task automatic add_result(input logic [7:0] b, input logic valid, input logic err);
    decoded_t r;
    r = '{data: b, byte_valid: valid, run_last: 1'b0, esc_err: err, lit_done: 1'b0};
    step_results.push_back(r);
  endtask

  // A bad digit reports one marker and drops the rest of the literal.
  task automatic flag_bad_digit();
    add_result(8'h00, 1'b0, 1'b1);
    skip_rest   = 1'b1;
    mode        = MODE_NORMAL;
    digits_left = 4'd0;
    code_accum  = 32'd0;
  endtask

  task automatic decode_body_byte(input logic [7:0] c, input logic lit_end);
    logic        digit_ok;
    logic [3:0]  digit;
    logic [7:0]  b;
    logic [31:0] lead;
    decoded_t    r;
    step_results.delete();
    if (skip_rest) begin
      // Nothing comes out until the literal closes.
    end else if (mode == MODE_ESCAPE) begin
      mode = MODE_NORMAL;
      if (c == CH_LOWER_X || c == CH_LOWER_U || c == CH_UPPER_U) begin
        mode        = MODE_HEX;
        digits_left = (c == CH_LOWER_X) ? DIGITS_X :
                      (c == CH_LOWER_U) ? DIGITS_LOWER_U : DIGITS_UPPER_U;
        code_accum  = 32'd0;
        if (lit_end) flag_bad_digit();
      end else begin
        case (c)
          "a":     b = 8'h07;
          "b":     b = 8'h08;
          "e":     b = 8'h1b;
          "f":     b = 8'h0c;
          "n":     b = 8'h0a;
          "r":     b = 8'h0d;
          "t":     b = 8'h09;
          default: b = c;
        endcase
        add_result(b, 1'b1, 1'b0);
      end
    end else if (mode == MODE_HEX) begin
      digit_ok = 1'b1;
      digit    = 4'd0;
      if (c >= "0" && c <= "9") digit = 4'(c - "0");
      else if (c >= "a" && c <= "f") digit = 4'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") digit = 4'(c - "A" + 8'd10);
      else digit_ok = 1'b0;
      if (!digit_ok || digits_left == 4'd0) begin
        flag_bad_digit();
      end else begin
        code_accum  = {code_accum[27:0], digit};
        digits_left = digits_left - 4'd1;
        if (digits_left == 4'd0) begin
          mode = MODE_NORMAL;
          if (code_accum < CP_LIMIT1) begin
            add_result(code_accum[7:0], 1'b1, 1'b0);
          end else if (code_accum < CP_LIMIT2) begin
            lead = 32'(UTF8_LEAD2) | (code_accum >> 6);
            add_result(lead[7:0], 1'b1, 1'b0);
          end else if (code_accum < CP_LIMIT3) begin
            lead = 32'(UTF8_LEAD3) | (code_accum >> 12);
            add_result(lead[7:0], 1'b1, 1'b0);
            add_result(UTF8_CONT | {2'b00, code_accum[11:6]}, 1'b1, 1'b0);
          end else begin
            // The lead byte keeps only its low eight bits for huge values.
            lead = 32'(UTF8_LEAD4) | (code_accum >> 18);
            add_result(lead[7:0], 1'b1, 1'b0);
            add_result(UTF8_CONT | {2'b00, code_accum[17:12]}, 1'b1, 1'b0);
            add_result(UTF8_CONT | {2'b00, code_accum[11:6]}, 1'b1, 1'b0);
          end
          if (code_accum >= CP_LIMIT1) begin
            add_result(UTF8_CONT | {2'b00, code_accum[5:0] & UTF8_MASK}, 1'b1, 1'b0);
          end
          code_accum = 32'd0;
        end else if (lit_end) begin
          flag_bad_digit();
        end
      end
    end else begin
      mode = MODE_NORMAL;
      if (c == CH_BACKSLASH) mode = MODE_ESCAPE;
      else add_result(c, 1'b1, 1'b0);
    end

    if (lit_end) begin
      if (step_results.size() == 0) add_result(8'h00, 1'b0, 1'b0);
      r = step_results.pop_back();
      r.lit_done = 1'b1;
      step_results.push_back(r);
      mode        = MODE_NORMAL;
      digits_left = 4'd0;
      code_accum  = 32'd0;
      skip_rest   = 1'b0;
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.run_last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_bytes.push_back(step_results[i]);
  endtask

  always @(posedge clk) begin : watch_channels
    decoded_t want;
    decoded_t got;
    if (!rst_n) begin
      expected_bytes.delete();
      mode        = MODE_NORMAL;
      digits_left = 4'd0;
      code_accum  = 32'd0;
      skip_rest   = 1'b0;
      mismatches  = 0;
      checked     = 0;
    end else begin
      if (in_tvalid && in_tready) decode_body_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata, byte_valid: out_tuser[0], run_last: out_tlast,
                esc_err: out_tuser[1], lit_done: out_tuser[2]};
        checked++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing pending: byte %02h valid %0b last %0b err %0b done %0b",
                     $realtime, got.data, got.byte_valid, got.run_last, got.esc_err, got.lit_done);
          end
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected byte %02h valid %0b last %0b err %0b done %0b",
                       $realtime, want.data, want.byte_valid, want.run_last, want.esc_err,
                       want.lit_done);
              $display("%0t:           got      byte %02h valid %0b last %0b err %0b done %0b",
                       $realtime, got.data, got.byte_valid, got.run_last, got.esc_err,
                       got.lit_done);
            end
          end
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import seu_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 200;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 150;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_EVERY_THIRD, READY_MOSTLY} ready_style_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;   // [7:0] in_char
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // [7:0] out_byte
  logic       out_tlast;
  logic [2:0] out_tuser;            // [0] byte_valid, [1] escape_error, [2] literal_done

  int mismatches;
  int pending;
  int checked;

  int cycle_count   = 0;
  int burst_left    = 0;
  int bytes_sent    = 0;
  int literals_sent = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int phase_left    = 0;
  int ready_tick    = 0;
  ready_style_t ready_style = READY_ALWAYS;

  string_escape_utf8_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  unescape_checker checker_inst (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results still pending.",
               cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver switches between stall patterns and serves long holds on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HoldCycles;
      out_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        ready_style = ready_style_t'($urandom_range(0, 3));
        phase_left  = $urandom_range(10, 60);
      end
      phase_left--;
      ready_tick++;
      case (ready_style)
        READY_ALWAYS:      out_tready <= 1'b1;
        READY_RANDOM:      out_tready <= 1'($urandom_range(0, 1));
        READY_EVERY_THIRD: out_tready <= (ready_tick % 3 == 0);
        default:           out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Sends one literal body byte by byte, in bursts with idle gaps between them.
  task automatic send_literal(input logic [7:0] body[$]);
    int gap;
    foreach (body[i]) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= body[i];
      in_tlast  <= (i == body.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
      burst_left--;
      bytes_sent++;
    end
    literals_sent++;
  endtask

  initial begin : stimulus
    logic [7:0]  body[$];
    logic [7:0]  ch;
    logic [3:0]  nib;
    logic [31:0] cp;
    int          random_bytes;
    int          n_elem;
    int          pick;
    int          kind;
    int          ndig;
    int          bad_pos;
    int          cut;
    bit          mid_hold;
    string       escape_letters;

    random_bytes   = 0;
    mid_hold       = 1'b0;
    escape_letters = "abefnrt";

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Byte extremes, then a plain escape.
    body = '{8'h00, 8'hff};
    send_literal(body);
    body = '{CH_BACKSLASH, "n"};
    send_literal(body);
    // A bad hex digit, followed by bytes that must be dropped.
    body = '{CH_BACKSLASH, CH_LOWER_X, "4", "G", "z", "z"};
    send_literal(body);
    // A backslash that closes the literal.
    body = '{CH_BACKSLASH};
    send_literal(body);
    // Hex escapes cut short by the end of the literal.
    body = '{CH_BACKSLASH, CH_LOWER_U, "1"};
    send_literal(body);
    body = '{CH_BACKSLASH, CH_LOWER_X};
    send_literal(body);
    // The largest code point, whose lead byte gets truncated.
    body = '{CH_BACKSLASH, CH_UPPER_U, "F", "F", "F", "F", "f", "f", "f", "f"};
    send_literal(body);

    hold_requests++;
    while (random_bytes < RandomItems) begin
      if (!mid_hold && random_bytes >= RandomItems / 2) begin
        hold_requests++;
        mid_hold = 1'b1;
      end
      body.delete();
      n_elem = $urandom_range(1, 8);
      repeat (n_elem) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          body.push_back(8'($urandom));
        end else if (pick < 60) begin
          body.push_back(CH_BACKSLASH);
          if ($urandom_range(0, 3) == 0) body.push_back(8'($urandom));
          else body.push_back(escape_letters[$urandom_range(0, 6)]);
        end else begin
          kind = $urandom_range(0, 2);
          ndig = (kind == 0) ? 2 : (kind == 1) ? 4 : 8;
          body.push_back(CH_BACKSLASH);
          body.push_back((kind == 0) ? CH_LOWER_X : (kind == 1) ? CH_LOWER_U : CH_UPPER_U);
          // Shifting spreads the code points over all UTF-8 lengths.
          cp      = $urandom >> $urandom_range(0, 31);
          bad_pos = (pick >= 88) ? $urandom_range(0, ndig - 1) : ndig;
          for (int i = 0; i < ndig; i++) begin
            nib = cp[4 * (ndig - 1 - i) +: 4];
            if (i == bad_pos) begin
              do ch = 8'($urandom);
              while ((ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "f") ||
                     (ch >= "A" && ch <= "F"));
            end else if (nib < 4'd10) begin
              ch = 8'("0") + nib;
            end else if ($urandom_range(0, 1) == 1) begin
              ch = 8'("a") + nib - 8'd10;
            end else begin
              ch = 8'("A") + nib - 8'd10;
            end
            body.push_back(ch);
          end
        end
      end
      // Now and then the literal ends in the middle of an escape.
      if ($urandom_range(0, 9) == 0) begin
        cut  = $urandom_range(1, body.size());
        body = body[0:cut-1];
      end
      send_literal(body);
      random_bytes += body.size();
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d body bytes in %0d literals, including escapes, hex code points",
             bytes_sent, literals_sent);
    $display("of every UTF-8 length, bad digits and cut-short escapes; %0d results checked.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
